// File: hdl/vpw_pkg.sv
// Shared types and constants for the Verlet point step with walls.
// Used by the axis front, axis back and top level; no dependencies.
package vpw_pkg;

  localparam int POS_W       = 32;               // Q16.16 position width
  localparam int VEL_W       = POS_W + 1;        // exact pos - prev
  localparam int RAD_W       = 31;
  localparam int BNC_W       = 17;               // bounce, Q1.16
  localparam int BOUNCE_FRAC = 16;
  localparam int REFL_W      = (VEL_W + 1) + (BNC_W + 1);  // -vel * bounce
  localparam int DT_W        = 32;
  localparam int ACC_W       = POS_W + DT_W + 1;          // accel * dt_squared
  localparam int SUM_W       = ACC_W + 1;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int NUM_AXES    = 3;
  localparam int AXIS_Y      = 1;

  localparam logic [RAD_W-1:0] WALL_RESET = RAD_W'(655360);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACCEL_X = 3'd0,
    CFG_ACCEL_Y = 3'd1,
    CFG_ACCEL_Z = 3'd2,
    CFG_DT_SQ   = 3'd3,
    CFG_BOUNCE  = 3'd4,
    CFG_WALL    = 3'd5
  } cfg_idx_t;

  // One axis after clamping, with both products ready for rounding
  typedef struct packed {
    logic                     frozen;
    logic                     hit;
    logic signed [POS_W-1:0]  base;
    logic signed [POS_W-1:0]  old;
    logic signed [VEL_W-1:0]  vel;
    logic signed [REFL_W-1:0] refl_prod;
    logic signed [ACC_W-1:0]  acc_prod;
  } axis_mid_t;

endpackage

// File: hdl/vpw_axis_front.sv
// First half of one axis: velocity, wall clamp and the two products.
// Depends on vpw_pkg.
module vpw_axis_front
  import vpw_pkg::*;
(
  input  logic signed [POS_W-1:0] pos,
  input  logic signed [POS_W-1:0] prev,
  input  logic signed [POS_W:0]   lo,
  input  logic signed [POS_W:0]   hi,
  input  logic                    hi_en,
  input  logic                    frozen,
  input  logic signed [POS_W-1:0] accel,
  input  logic [DT_W-1:0]         dt_sq,
  input  logic [BNC_W-1:0]        bounce,
  output axis_mid_t               mid
);

  logic signed [POS_W:0]    pos_w;
  logic signed [VEL_W-1:0]  vel;
  logic signed [VEL_W:0]    neg_vel;
  logic                     hit_hi;
  logic                     hit_lo;
  logic signed [POS_W-1:0]  clamped;
  logic signed [REFL_W-1:0] refl_prod;
  logic signed [ACC_W-1:0]  acc_prod;

  assign pos_w   = {pos[POS_W-1], pos};
  assign vel     = pos_w - {prev[POS_W-1], prev};
  assign neg_vel = -{vel[VEL_W-1], vel};

  // upper wall takes priority when the radius is wider than the gap
  assign hit_hi  = hi_en && (pos_w > hi);
  assign hit_lo  = !hit_hi && (pos_w < lo);
  assign clamped = hit_hi ? hi[POS_W-1:0] : (hit_lo ? lo[POS_W-1:0] : pos);

  assign refl_prod = neg_vel * $signed({1'b0, bounce});
  assign acc_prod  = accel * $signed({1'b0, dt_sq});

  always_comb begin
    mid.frozen    = frozen;
    mid.hit       = hit_hi || hit_lo;
    mid.base      = frozen ? pos : clamped;
    mid.old       = frozen ? prev : clamped;
    mid.vel       = vel;
    mid.refl_prod = refl_prod;
    mid.acc_prod  = acc_prod;
  end

endmodule

// File: hdl/vpw_axis_back.sv
// Second half of one axis: rounding, Verlet sum and saturation.
// Depends on vpw_pkg.
module vpw_axis_back
  import vpw_pkg::*;
#(
  parameter int FRAC_BITS = 16
)
(
  input  axis_mid_t               mid,
  output logic signed [POS_W-1:0] new_pos,
  output logic signed [POS_W-1:0] old_pos
);

  localparam logic signed [REFL_W-1:0] REFL_HALF = REFL_W'(1) << (BOUNCE_FRAC - 1);
  localparam logic signed [ACC_W-1:0]  ACC_HALF  = ACC_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [SUM_W-1:0]  SAT_MAX   = SUM_W'(2147483647);
  localparam logic signed [SUM_W-1:0]  SAT_MIN   = -SAT_MAX - SUM_W'(1);

  logic signed [REFL_W-1:0] refl_rnd;
  logic signed [REFL_W-1:0] refl_vel;
  logic signed [REFL_W-1:0] vel_sel;
  logic signed [ACC_W-1:0]  acc_rnd;
  logic signed [ACC_W-1:0]  acc_step;
  logic signed [SUM_W-1:0]  sum;
  logic signed [POS_W-1:0]  sat;

  // round to nearest, ties up: add half then floor
  assign refl_rnd = $signed(mid.refl_prod) + REFL_HALF;
  assign refl_vel = refl_rnd >>> BOUNCE_FRAC;
  assign vel_sel  = mid.hit ? refl_vel : REFL_W'($signed(mid.vel));

  assign acc_rnd  = $signed(mid.acc_prod) + ACC_HALF;
  assign acc_step = acc_rnd >>> FRAC_BITS;

  assign sum = SUM_W'($signed(mid.base)) + SUM_W'(vel_sel) + SUM_W'(acc_step);

  always_comb begin
    if (sum > SAT_MAX) begin
      sat = SAT_MAX[POS_W-1:0];
    end else if (sum < SAT_MIN) begin
      sat = SAT_MIN[POS_W-1:0];
    end else begin
      sat = sum[POS_W-1:0];
    end
  end

  assign new_pos = mid.frozen ? $signed(mid.base) : sat;
  assign old_pos = $signed(mid.old);

endmodule

// File: hdl/verlet_point_step_with_walls.sv
// Verlet point step with floor and side walls: one particle per beat, one
// result per particle, through three registers (input, product, result).
// A new particle is taken every cycle unless the output stalls; the rate
// is set by one multiplier pair per axis in the middle stage, each fed once
// per cycle. A stall on the output fills the empty stages before the input
// is stalled. Configuration writes apply from the particle in the input
// register on. Depends on vpw_pkg, vpw_axis_front and vpw_axis_back.
module verlet_point_step_with_walls
  import vpw_pkg::*;
#(
  parameter int FRAC_BITS = 16
)
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [POS_W-1:0] in_pos_x,
  input  logic signed [POS_W-1:0] in_pos_y,
  input  logic signed [POS_W-1:0] in_pos_z,
  input  logic signed [POS_W-1:0] in_prev_x,
  input  logic signed [POS_W-1:0] in_prev_y,
  input  logic signed [POS_W-1:0] in_prev_z,
  input  logic [RAD_W-1:0]        in_radius,
  input  logic                    in_frozen,
  input  logic                    in_last_point,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [POS_W-1:0] out_new_x,
  output logic signed [POS_W-1:0] out_new_y,
  output logic signed [POS_W-1:0] out_new_z,
  output logic signed [POS_W-1:0] out_old_x,
  output logic signed [POS_W-1:0] out_old_y,
  output logic signed [POS_W-1:0] out_old_z,
  output logic                    out_last_out
);

  // configuration
  logic signed [POS_W-1:0] accel_r [NUM_AXES];
  logic [DT_W-1:0]         dt_sq_r;
  logic [BNC_W-1:0]        bounce_r;
  logic [RAD_W-1:0]        wall_r;

  // pipeline
  logic                    s0_valid_r;
  logic                    s1_valid_r;
  logic                    out_valid_r;
  logic                    rdy0;
  logic                    rdy1;
  logic                    rdy2;

  logic signed [POS_W-1:0] s0_pos_r  [NUM_AXES];
  logic signed [POS_W-1:0] s0_prev_r [NUM_AXES];
  logic [RAD_W-1:0]        s0_radius_r;
  logic                    s0_frozen_r;
  logic                    s0_last_r;

  axis_mid_t               s1_mid_nxt [NUM_AXES];
  axis_mid_t               s1_mid_r   [NUM_AXES];
  logic                    s1_last_r;

  logic signed [POS_W-1:0] out_new_nxt [NUM_AXES];
  logic signed [POS_W-1:0] out_old_nxt [NUM_AXES];
  logic signed [POS_W-1:0] out_new_r   [NUM_AXES];
  logic signed [POS_W-1:0] out_old_r   [NUM_AXES];
  logic                    out_last_r;

  logic signed [POS_W:0]   rad_w;
  logic signed [POS_W:0]   side_hi;
  logic signed [POS_W:0]   side_lo;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        accel_r[i] <= '0;
      end
      dt_sq_r  <= '0;
      bounce_r <= '0;
      wall_r   <= WALL_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_idx_t'(cfg_index))
        CFG_ACCEL_X: accel_r[0] <= $signed(cfg_wdata[POS_W-1:0]);
        CFG_ACCEL_Y: accel_r[1] <= $signed(cfg_wdata[POS_W-1:0]);
        CFG_ACCEL_Z: accel_r[2] <= $signed(cfg_wdata[POS_W-1:0]);
        CFG_DT_SQ:   dt_sq_r    <= cfg_wdata[DT_W-1:0];
        CFG_BOUNCE:  bounce_r   <= cfg_wdata[BNC_W-1:0];
        CFG_WALL:    wall_r     <= cfg_wdata[RAD_W-1:0];
        default: ;
      endcase
    end
  end

  // each stage advances when it is empty or the stage after it moves
  assign rdy2     = !out_valid_r || !out_stall;
  assign rdy1     = !s1_valid_r || rdy2;
  assign rdy0     = !s0_valid_r || rdy1;
  assign in_stall = !rdy0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r  <= 1'b0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy0) begin
        s0_valid_r <= in_valid;
      end
      if (rdy1) begin
        s1_valid_r <= s0_valid_r;
      end
      if (rdy2) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && rdy0) begin
      s0_pos_r[0]  <= in_pos_x;
      s0_pos_r[1]  <= in_pos_y;
      s0_pos_r[2]  <= in_pos_z;
      s0_prev_r[0] <= in_prev_x;
      s0_prev_r[1] <= in_prev_y;
      s0_prev_r[2] <= in_prev_z;
      s0_radius_r  <= in_radius;
      s0_frozen_r  <= in_frozen;
      s0_last_r    <= in_last_point;
    end
    if (s0_valid_r && rdy1) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        s1_mid_r[i] <= s1_mid_nxt[i];
      end
      s1_last_r <= s0_last_r;
    end
    if (s1_valid_r && rdy2) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        out_new_r[i] <= out_new_nxt[i];
        out_old_r[i] <= out_old_nxt[i];
      end
      out_last_r <= s1_last_r;
    end
  end

  // wall bounds; the floor uses the radius as its lower bound only
  assign rad_w   = $signed({2'b00, s0_radius_r});
  assign side_hi = $signed({2'b00, wall_r}) - rad_w;
  assign side_lo = rad_w - $signed({2'b00, wall_r});

  for (genvar ax = 0; ax < NUM_AXES; ax++) begin : g_axis
    vpw_axis_front u_front (
      .pos    (s0_pos_r[ax]),
      .prev   (s0_prev_r[ax]),
      .lo     ((ax == AXIS_Y) ? rad_w : side_lo),
      .hi     (side_hi),
      .hi_en  (ax != AXIS_Y),
      .frozen (s0_frozen_r),
      .accel  (accel_r[ax]),
      .dt_sq  (dt_sq_r),
      .bounce (bounce_r),
      .mid    (s1_mid_nxt[ax])
    );

    vpw_axis_back #(
      .FRAC_BITS (FRAC_BITS)
    ) u_back (
      .mid     (s1_mid_r[ax]),
      .new_pos (out_new_nxt[ax]),
      .old_pos (out_old_nxt[ax])
    );
  end

  assign out_valid    = out_valid_r;
  assign out_new_x    = out_new_r[0];
  assign out_new_y    = out_new_r[1];
  assign out_new_z    = out_new_r[2];
  assign out_old_x    = out_old_r[0];
  assign out_old_y    = out_old_r[1];
  assign out_old_z    = out_old_r[2];
  assign out_last_out = out_last_r;

  a_reset_empties: assert property (@(posedge clk) !rst_n |=> !out_valid_r && !s0_valid_r)
    else $error("pipeline not empty after reset");

  a_full_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (s0_valid_r && s1_valid_r && out_valid_r && out_stall) |-> in_stall)
    else $error("input taken while every stage is held");

  a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (s0_valid_r && rdy1) |=> s1_valid_r)
    else $error("beat lost between input and product stage");

  a_floor_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_mid_r[AXIS_Y].frozen) |-> !s1_mid_r[AXIS_Y].old[POS_W-1])
    else $error("clamped y below the floor");

endmodule
